// ===== hdl/mspa_pkg.sv =====
// ----------------------------------------------------------------------------
// mspa_pkg
// shared types, codes and saturation helpers of the masked saturating pixel alu
// ----------------------------------------------------------------------------
package mspa_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_MUL     = 3'd1,
    OP_SUB     = 3'd2,
    OP_DIV     = 3'd3,
    OP_MOD     = 3'd4,
    OP_ABSDIFF = 3'd5,
    OP_MIN     = 3'd6,
    OP_MAX     = 3'd7
  } op_t;

  localparam logic [2:0] ET_U8  = 3'd0;
  localparam logic [2:0] ET_U16 = 3'd1;
  localparam logic [2:0] ET_U32 = 3'd2;
  localparam logic [2:0] ET_S8  = 3'd3;
  localparam logic [2:0] ET_S16 = 3'd4;
  localparam logic [2:0] ET_S32 = 3'd5;

  // register indexes, byte address is index times four
  localparam logic [2:0] REG_OPERATION         = 3'd0;
  localparam logic [2:0] REG_ELEMENT_TYPE      = 3'd1;
  localparam logic [2:0] REG_CHANNELS_USED     = 3'd2;
  localparam logic [2:0] REG_SOURCE_BROADCAST  = 3'd3;
  localparam logic [2:0] REG_OPERAND_BROADCAST = 3'd4;
  localparam logic [2:0] REG_MASK_ENABLE       = 3'd5;

  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned ND_DEPTH   = DIV_STAGES - 2;
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + 2;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] ub;
    logic [31:0] ua;
    logic        neg_q;
    logic        neg_r;
    logic        bz;
  } div_stage_t;

  function automatic logic signed [33:0] decode(logic [31:0] raw, logic [2:0] et);
    logic signed [33:0] v;
    case (et)
      ET_U8:   v = {26'd0, raw[7:0]};
      ET_U16:  v = {18'd0, raw[15:0]};
      ET_U32:  v = {2'd0, raw};
      ET_S8:   v = {{26{raw[7]}}, raw[7:0]};
      ET_S16:  v = {{18{raw[15]}}, raw[15:0]};
      ET_S32:  v = {{2{raw[31]}}, raw};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat(logic [63:0] mag, logic neg, logic [2:0] et);
    logic [31:0] msk;
    logic [63:0] half;
    logic [63:0] m;
    logic        sgn;
    logic [31:0] r;
    case (et)
      ET_U8:   begin msk = 32'h0000_00ff; sgn = 1'b0; end
      ET_U16:  begin msk = 32'h0000_ffff; sgn = 1'b0; end
      ET_U32:  begin msk = 32'hffff_ffff; sgn = 1'b0; end
      ET_S8:   begin msk = 32'h0000_00ff; sgn = 1'b1; end
      ET_S16:  begin msk = 32'h0000_ffff; sgn = 1'b1; end
      ET_S32:  begin msk = 32'hffff_ffff; sgn = 1'b1; end
      default: begin msk = 32'h0; sgn = 1'b0; end
    endcase
    half = {32'd0, 1'b0, msk[31:1]} + 64'd1;
    if (!sgn) begin
      if (neg) r = '0;
      else if (mag > {32'd0, msk}) r = msk;
      else r = mag[31:0];
    end else if (neg) begin
      m = (mag > half) ? half : mag;
      r = (32'd0 - m[31:0]) & msk;
    end else begin
      m = (mag > half - 64'd1) ? half - 64'd1 : mag;
      r = m[31:0] & msk;
    end
    return r;
  endfunction

endpackage

// ===== hdl/mspa_div.sv =====
// ----------------------------------------------------------------------------
// mspa_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module mspa_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            ua,
  input  logic [31:0]            ub,
  input  logic                   neg_q,
  input  logic                   neg_r,
  output mspa_pkg::div_stage_t   res
);

  mspa_pkg::div_stage_t stg [mspa_pkg::DIV_STAGES];
  mspa_pkg::div_stage_t stg_next [mspa_pkg::DIV_STAGES];

  always_comb begin
    mspa_pkg::div_stage_t cur;
    logic [32:0] tmp;
    for (int k = 0; k < mspa_pkg::DIV_STAGES; k++) begin
      if (k == 0) begin
        cur.rem = '0;
        cur.num = ua;
        cur.quo = '0;
        cur.ub = ub;
        cur.ua = ua;
        cur.neg_q = neg_q;
        cur.neg_r = neg_r;
        cur.bz = (ub == 32'd0);
      end else begin
        cur = stg[k-1];
      end
      tmp = {cur.rem, cur.num[31]};
      stg_next[k] = cur;
      stg_next[k].num = {cur.num[30:0], 1'b0};
      if (tmp >= {1'b0, cur.ub}) begin
        stg_next[k].rem = 32'(tmp - {1'b0, cur.ub});
        stg_next[k].quo = {cur.quo[30:0], 1'b1};
      end else begin
        stg_next[k].rem = tmp[31:0];
        stg_next[k].quo = {cur.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mspa_pkg::DIV_STAGES; k++) stg[k] <= stg_next[k];
    end
  end

  assign res = stg[mspa_pkg::DIV_STAGES-1];

endmodule

// ===== hdl/mspa_lane.sv =====
// ----------------------------------------------------------------------------
// mspa_lane
// one channel: decode, arithmetic, divide and saturation
// ----------------------------------------------------------------------------
module mspa_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [2:0]  op,
  input  logic [2:0]  etype,
  input  logic [31:0] a_raw,
  input  logic [31:0] b_raw,
  output logic [31:0] res
);

  logic signed [33:0] a;
  logic signed [33:0] b;
  logic [31:0] ua;
  logic [31:0] ub;
  logic [63:0] mag2;
  logic        neg2;
  logic [31:0] sat3;
  logic [31:0] nd [mspa_pkg::ND_DEPTH];
  logic signed [34:0] simple;
  logic [34:0] simple_mag;
  mspa_pkg::div_stage_t dres;
  logic [32:0] quo_r;
  logic [31:0] div_res;
  logic [31:0] mod_res;

  // decode
  always_ff @(posedge clk) begin
    if (en) begin
      a <= mspa_pkg::decode(a_raw, etype);
      b <= mspa_pkg::decode(b_raw, etype);
    end
  end

  assign ua = a[33] ? 32'(-a) : a[31:0];
  assign ub = b[33] ? 32'(-b) : b[31:0];

  always_comb begin
    case (op)
      mspa_pkg::OP_ADD:     simple = 35'(a) + 35'(b);
      mspa_pkg::OP_SUB:     simple = 35'(a) - 35'(b);
      mspa_pkg::OP_ABSDIFF: simple = (a > b) ? 35'(a) - 35'(b) : 35'(b) - 35'(a);
      mspa_pkg::OP_MIN:     simple = (a < b) ? 35'(a) : 35'(b);
      mspa_pkg::OP_MAX:     simple = (a > b) ? 35'(a) : 35'(b);
      default:              simple = '0;
    endcase
    simple_mag = simple[34] ? 35'(-simple) : simple;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (op == mspa_pkg::OP_MUL) begin
        mag2 <= 64'(ua) * 64'(ub);
        neg2 <= a[33] ^ b[33];
      end else begin
        mag2 <= 64'(simple_mag);
        neg2 <= simple[34];
      end
      sat3 <= mspa_pkg::sat(mag2, neg2, etype);
      nd[0] <= sat3;
      for (int k = 1; k < mspa_pkg::ND_DEPTH; k++) nd[k] <= nd[k-1];
    end
  end

  mspa_div u_div (
    .clk   (clk),
    .en    (en),
    .ua    (ua),
    .ub    (ub),
    .neg_q (a[33] ^ b[33]),
    .neg_r (a[33]),
    .res   (dres)
  );

  // round half away from zero on the magnitude
  assign quo_r = {1'b0, dres.quo} + 33'({dres.rem, 1'b0} >= {1'b0, dres.ub});

  always_comb begin
    div_res = dres.bz ? 32'd0 : mspa_pkg::sat(64'(quo_r), dres.neg_q, etype);
    mod_res = dres.bz ? mspa_pkg::sat(64'(dres.ua), dres.neg_r, etype)
                      : mspa_pkg::sat(64'(dres.rem), dres.neg_r, etype);
    case (op)
      mspa_pkg::OP_DIV: res = div_res;
      mspa_pkg::OP_MOD: res = mod_res;
      default:          res = nd[mspa_pkg::ND_DEPTH-1];
    endcase
  end

endmodule

// ===== hdl/masked_saturating_pixel_alu.sv =====
// ----------------------------------------------------------------------------
// masked_saturating_pixel_alu
// per-channel saturating pixel arithmetic with broadcast and pixel mask
// ----------------------------------------------------------------------------
// Takes one pixel per cycle; its result passes the input register, the lane
// decode register, the 32-stage pipelined divider in each channel lane, which
// every operation passes alongside, and the output register. Throughput is one
// pixel per clock with no stall unless the output side holds m_tready low.
// Configuration registers must be written only while no pixel is in flight.
module masked_saturating_pixel_alu #(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [255:0] s_tdata,   // src_ch0..src_ch3, opnd_ch0..opnd_ch3
  input  logic [0:0]   s_tuser,   // pixel_mask
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // result_ch0..result_ch3, write_enable, pad
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned NC = mspa_pkg::NUM_CH;
  localparam int unsigned PD = mspa_pkg::PIPE_DEPTH;

  logic [2:0] operation;
  logic [2:0] element_type;
  logic [2:0] channels_used;
  logic       source_broadcast;
  logic       operand_broadcast;
  logic       mask_enable;

  logic          en;
  logic [2:0]    n_eff;
  logic [NC-1:0] strobe;
  logic [31:0]   a_raw [NC];
  logic [31:0]   b_raw [NC];
  logic [31:0]   lane_res [NC];
  logic          vld [PD];
  logic [NC-1:0] stb [PD];
  logic [31:0]   result [NC];
  logic [NC-1:0] write_enable;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= mspa_pkg::OP_ADD;
      element_type <= mspa_pkg::ET_U8;
      channels_used <= 3'd1;
      source_broadcast <= 1'b0;
      operand_broadcast <= 1'b0;
      mask_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        mspa_pkg::REG_OPERATION:         operation <= pwdata[2:0];
        mspa_pkg::REG_ELEMENT_TYPE:      element_type <= pwdata[2:0];
        mspa_pkg::REG_CHANNELS_USED:     channels_used <= pwdata[2:0];
        mspa_pkg::REG_SOURCE_BROADCAST:  source_broadcast <= pwdata[0];
        mspa_pkg::REG_OPERAND_BROADCAST: operand_broadcast <= pwdata[0];
        mspa_pkg::REG_MASK_ENABLE:       mask_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mspa_pkg::REG_OPERATION:         prdata = {29'd0, operation};
      mspa_pkg::REG_ELEMENT_TYPE:      prdata = {29'd0, element_type};
      mspa_pkg::REG_CHANNELS_USED:     prdata = {29'd0, channels_used};
      mspa_pkg::REG_SOURCE_BROADCAST:  prdata = {31'd0, source_broadcast};
      mspa_pkg::REG_OPERAND_BROADCAST: prdata = {31'd0, operand_broadcast};
      mspa_pkg::REG_MASK_ENABLE:       prdata = {31'd0, mask_enable};
      default:                         prdata = '0;
    endcase
  end

  // channel strobes
  always_comb begin
    n_eff = (32'(channels_used) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : channels_used;
    if (element_type > mspa_pkg::ET_S32) n_eff = '0;
    if (mask_enable && !s_tuser[0]) n_eff = '0;
    for (int c = 0; c < NC; c++) strobe[c] = (3'(c) < n_eff);
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PD; k++) vld[k] <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < PD; k++) vld[k] <= vld[k-1];
      m_tvalid <= vld[PD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stb[0] <= strobe;
      for (int k = 1; k < PD; k++) stb[k] <= stb[k-1];
      for (int c = 0; c < NC; c++) begin
        a_raw[c] <= source_broadcast ? s_tdata[31:0] : s_tdata[32*c +: 32];
        b_raw[c] <= operand_broadcast ? s_tdata[159:128] : s_tdata[128 + 32*c +: 32];
      end
      for (int c = 0; c < NC; c++) result[c] <= stb[PD-1][c] ? lane_res[c] : 32'd0;
      write_enable <= stb[PD-1];
    end
  end

  for (genvar c = 0; c < NC; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_on
      mspa_lane u_lane (
        .clk   (clk),
        .en    (en),
        .op    (operation),
        .etype (element_type),
        .a_raw (a_raw[c]),
        .b_raw (b_raw[c]),
        .res   (lane_res[c])
      );
    end else begin : g_off
      assign lane_res[c] = '0;
    end
  end

  assign m_tdata = {4'd0, write_enable, result[3], result[2], result[1], result[0]};

  a_gated_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !write_enable[0] |-> result[0] == 32'd0)
    else $error("unwritten channel carries data");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with output stage");

  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result presented right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(write_enable))
    else $error("strobe changed while stalled");

endmodule
